// ----- hw/rtl/jpeg_block_huffman_encoder_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the block Huffman encoder
// ---------------------------------------------------------------------------
`ifndef JPEG_BLOCK_HUFFMAN_ENCODER_MACROS_SVH
`define JPEG_BLOCK_HUFFMAN_ENCODER_MACROS_SVH

// implication checked on every clock edge outside reset
`define JBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define JBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/jbh_pkg.sv -----
// ---------------------------------------------------------------------------
// jbh_pkg
// Shared types, constants and Huffman tables of the block encoder.
// ---------------------------------------------------------------------------
package jbh_pkg;

	localparam int BLOCK_SIZE = 64;
	localparam int RUN_LIMIT  = 16;
	localparam int SIZES_PER_RUN = 10;
	localparam int DC_MAX = 2047;
	localparam int AC_MAX = 1023;

	localparam logic [15:0] EOB_CODE = 16'h000A;
	localparam logic [4:0]  EOB_LEN  = 5'd4;
	localparam logic [15:0] ZRL_CODE = 16'h07F9;
	localparam logic [4:0]  ZRL_LEN  = 5'd11;

	localparam logic [1:0] KIND_DC  = 2'd0;
	localparam logic [1:0] KIND_AC  = 2'd1;
	localparam logic [1:0] KIND_ZRL = 2'd2;
	localparam logic [1:0] KIND_EOB = 2'd3;

	localparam logic REG_DC_PRED   = 1'b0;
	localparam logic REG_DEAD_ZONE = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DC,
		ST_READ,
		ST_SCAN,
		ST_ZRL,
		ST_EOB
	} jbh_state_t;

	// controller -> datapath
	typedef struct packed {
		logic       dc_emit;   // build DC symbol
		logic       rd_en;     // fetch next AC entry
		logic       ac_emit;   // build AC run/size symbol
		logic       zrl_emit;
		logic       eob_emit;
		logic       run_clr;
		logic       run_inc;
		logic       run_dec16;
		logic       last;      // symbol closes the block
	} jbh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       is_zero;   // fetched AC falls in the dead zone
		logic       run_ge16;
		logic       at_last;   // fetched AC is position 63
		logic       out_busy;  // output register holds an untaken beat
	} jbh_sts_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code;
		logic [4:0]  len;
		logic [10:0] amp;
		logic [3:0]  alen;
		logic        last;
	} jbh_sym_t;

	function automatic logic [5:0] zig_pos(input logic [5:0] r);
		logic [5:0] z;
		case (r)
			6'd0: z = 6'd0;   6'd1: z = 6'd1;   6'd2: z = 6'd5;   6'd3: z = 6'd6;
			6'd4: z = 6'd14;  6'd5: z = 6'd15;  6'd6: z = 6'd27;  6'd7: z = 6'd28;
			6'd8: z = 6'd2;   6'd9: z = 6'd4;   6'd10: z = 6'd7;  6'd11: z = 6'd13;
			6'd12: z = 6'd16; 6'd13: z = 6'd26; 6'd14: z = 6'd29; 6'd15: z = 6'd42;
			6'd16: z = 6'd3;  6'd17: z = 6'd8;  6'd18: z = 6'd12; 6'd19: z = 6'd17;
			6'd20: z = 6'd25; 6'd21: z = 6'd30; 6'd22: z = 6'd41; 6'd23: z = 6'd43;
			6'd24: z = 6'd9;  6'd25: z = 6'd11; 6'd26: z = 6'd18; 6'd27: z = 6'd24;
			6'd28: z = 6'd31; 6'd29: z = 6'd40; 6'd30: z = 6'd44; 6'd31: z = 6'd53;
			6'd32: z = 6'd10; 6'd33: z = 6'd19; 6'd34: z = 6'd23; 6'd35: z = 6'd32;
			6'd36: z = 6'd39; 6'd37: z = 6'd45; 6'd38: z = 6'd52; 6'd39: z = 6'd54;
			6'd40: z = 6'd20; 6'd41: z = 6'd22; 6'd42: z = 6'd33; 6'd43: z = 6'd38;
			6'd44: z = 6'd46; 6'd45: z = 6'd51; 6'd46: z = 6'd55; 6'd47: z = 6'd60;
			6'd48: z = 6'd21; 6'd49: z = 6'd34; 6'd50: z = 6'd37; 6'd51: z = 6'd47;
			6'd52: z = 6'd50; 6'd53: z = 6'd56; 6'd54: z = 6'd59; 6'd55: z = 6'd61;
			6'd56: z = 6'd35; 6'd57: z = 6'd36; 6'd58: z = 6'd48; 6'd59: z = 6'd49;
			6'd60: z = 6'd57; 6'd61: z = 6'd58; 6'd62: z = 6'd62; default: z = 6'd63;
		endcase
		return z;
	endfunction

	function automatic logic [15:0] dc_code(input logic [3:0] c);
		logic [15:0] v;
		case (c)
			4'd0: v = 16'h000; 4'd1: v = 16'h002; 4'd2: v = 16'h003; 4'd3: v = 16'h004;
			4'd4: v = 16'h005; 4'd5: v = 16'h006; 4'd6: v = 16'h00E; 4'd7: v = 16'h01E;
			4'd8: v = 16'h03E; 4'd9: v = 16'h07E; 4'd10: v = 16'h0FE;
			default: v = 16'h1FE;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] dc_len(input logic [3:0] c);
		logic [4:0] v;
		case (c)
			4'd0: v = 5'd2;
			4'd1, 4'd2, 4'd3, 4'd4, 4'd5: v = 5'd3;
			4'd6: v = 5'd4; 4'd7: v = 5'd5; 4'd8: v = 5'd6; 4'd9: v = 5'd7;
			4'd10: v = 5'd8;
			default: v = 5'd9;
		endcase
		return v;
	endfunction

	// rank of a long code among the 16-bit entries in table order
	function automatic logic [7:0] long_rank(input logic [7:0] idx);
		logic [7:0] r;
		if (idx < 8'd10)       r = idx - 8'd8;
		else if (idx < 8'd20)  r = idx - 8'd13;
		else if (idx < 8'd30)  r = idx - 8'd17;
		else if (idx < 8'd40)  r = idx - 8'd20;
		else if (idx < 8'd50)  r = idx - 8'd22;
		else if (idx < 8'd60)  r = idx - 8'd24;
		else if (idx < 8'd70)  r = idx - 8'd26;
		else if (idx < 8'd80)  r = idx - 8'd28;
		else if (idx < 8'd90)  r = idx - 8'd30;
		else if (idx < 8'd100) r = idx - 8'd31;
		else if (idx < 8'd110) r = idx - 8'd32;
		else if (idx < 8'd120) r = idx - 8'd33;
		else if (idx < 8'd130) r = idx - 8'd34;
		else                   r = idx - 8'd35;
		return r;
	endfunction

	// AC code word by run and size; entries not listed follow the long-code
	// rule 0xFF82 + index - 8 (shifted by the short codes in between)
	function automatic logic [15:0] ac_code(input logic [3:0] run, input logic [3:0] size);
		logic [7:0]  idx;
		logic [15:0] v;
		idx = 8'(run) * 8'd10 + 8'(size) - 8'd1;
		case (idx)
			8'd0: v = 16'h0000; 8'd1: v = 16'h0001; 8'd2: v = 16'h0004; 8'd3: v = 16'h000B;
			8'd4: v = 16'h001A; 8'd5: v = 16'h0078; 8'd6: v = 16'h00F8; 8'd7: v = 16'h03F6;
			8'd10: v = 16'h000C; 8'd11: v = 16'h001B; 8'd12: v = 16'h0079;
			8'd13: v = 16'h01F6; 8'd14: v = 16'h07F6;
			8'd20: v = 16'h001C; 8'd21: v = 16'h00F9; 8'd22: v = 16'h03F7; 8'd23: v = 16'h0FF4;
			8'd30: v = 16'h003A; 8'd31: v = 16'h01F7; 8'd32: v = 16'h0FF5;
			8'd40: v = 16'h003B; 8'd41: v = 16'h03F8;
			8'd50: v = 16'h007A; 8'd51: v = 16'h07F7;
			8'd60: v = 16'h007B; 8'd61: v = 16'h0FF6;
			8'd70: v = 16'h00FA; 8'd71: v = 16'h0FF7;
			8'd80: v = 16'h01F8; 8'd81: v = 16'h7FC0;
			8'd90: v = 16'h01F9; 8'd100: v = 16'h01FA;
			8'd110: v = 16'h03F9; 8'd120: v = 16'h03FA; 8'd130: v = 16'h07F8;
			default: v = 16'hFF82 + 16'(long_rank(idx));
		endcase
		return v;
	endfunction

	function automatic logic [4:0] ac_len(input logic [3:0] run, input logic [3:0] size);
		logic [7:0] idx;
		logic [4:0] v;
		idx = 8'(run) * 8'd10 + 8'(size) - 8'd1;
		case (idx)
			8'd0, 8'd1: v = 5'd2; 8'd2: v = 5'd3; 8'd3: v = 5'd4; 8'd4: v = 5'd5;
			8'd5: v = 5'd7; 8'd6: v = 5'd8; 8'd7: v = 5'd10;
			8'd10: v = 5'd4; 8'd11: v = 5'd5; 8'd12: v = 5'd7; 8'd13: v = 5'd9;
			8'd14: v = 5'd11;
			8'd20: v = 5'd5; 8'd21: v = 5'd8; 8'd22: v = 5'd10; 8'd23: v = 5'd12;
			8'd30: v = 5'd6; 8'd31: v = 5'd9; 8'd32: v = 5'd12;
			8'd40: v = 5'd6; 8'd41: v = 5'd10;
			8'd50: v = 5'd7; 8'd51: v = 5'd11;
			8'd60: v = 5'd7; 8'd61: v = 5'd12;
			8'd70: v = 5'd8; 8'd71: v = 5'd12;
			8'd80: v = 5'd9; 8'd81: v = 5'd15;
			8'd90: v = 5'd9; 8'd100: v = 5'd9;
			8'd110: v = 5'd10; 8'd120: v = 5'd10; 8'd130: v = 5'd11;
			default: v = 5'd16;
		endcase
		return v;
	endfunction

	// bit length of a magnitude of up to 11 bits
	function automatic logic [3:0] category(input logic [10:0] mag);
		logic [3:0] c;
		c = 4'd0;
		for (int i = 0; i < 11; i++) begin
			if (mag[i]) c = 4'(i + 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/jpeg_block_huffman_encoder.sv -----
// After the 64th coefficient the controller enters its DC state, which registers
// the DC symbol in the output register once that register holds no untaken beat.
// The scan reads each AC position, then tests it; ZRL and EOB symbols have their
// own states. There is one block store, so no loading happens during the scan.
// Reset clears control, load index and predictor; the block store is not cleared.
// ---------------------------------------------------------------------------
// jpeg_block_huffman_encoder
// Zigzag store and baseline luminance Huffman symbol encoder for 8x8 blocks.
// ---------------------------------------------------------------------------
module jpeg_block_huffman_encoder #(
	parameter int COEFF_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [15:0]            s_axis_tdata,   // coefficient
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// code_bits, code_length, amplitude_bits, amplitude_length, pad
	output logic [39:0]            m_axis_tdata,
	output logic [1:0]             m_axis_tuser,   // symbol_kind
	output logic                   m_axis_tlast,   // block_end
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [3:0]             cfg_data
);

	logic dc_pred_q;
	logic [3:0] dead_zone_q;
	logic loading, blk_full, wr_en, out_valid;
	jbh_pkg::jbh_cmd_t cmd;
	jbh_pkg::jbh_sts_t sts;
	jbh_pkg::jbh_sym_t sym;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_pred_q   <= 1'b0;
			dead_zone_q <= 4'd1;
		end else if (cfg_valid) begin
			if (cfg_index == jbh_pkg::REG_DC_PRED) dc_pred_q <= cfg_data[0];
			else dead_zone_q <= cfg_data;
		end
	end

	assign s_axis_tready = loading;
	assign wr_en = s_axis_tvalid && loading;

	jbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.blk_full (blk_full),
		.sts      (sts),
		.cmd      (cmd),
		.loading  (loading)
	);

	jbh_datapath #(.COEFF_WIDTH(COEFF_WIDTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_data    (s_axis_tdata[COEFF_WIDTH-1:0]),
		.blk_full   (blk_full),
		.dc_pred_en (dc_pred_q),
		.dead_zone  (dead_zone_q),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_ready  (m_axis_tready),
		.out_sym    (sym)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {4'd0, sym.alen, sym.amp, sym.len, sym.code};
	assign m_axis_tuser  = sym.kind;
	assign m_axis_tlast  = sym.last;

endmodule

// ----- hw/rtl/jbh_ctrl.sv -----
// ---------------------------------------------------------------------------
// jbh_ctrl
// Sequencer: loads a block, then walks the zigzag store and issues symbols.
// ---------------------------------------------------------------------------
module jbh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                blk_full,   // 64th coefficient accepted
	input  jbh_pkg::jbh_sts_t   sts,
	output jbh_pkg::jbh_cmd_t   cmd,
	output logic                loading
);

	jbh_pkg::jbh_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jbh_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			jbh_pkg::ST_LOAD: if (blk_full) state_d = jbh_pkg::ST_DC;
			jbh_pkg::ST_DC: if (!sts.out_busy) state_d = jbh_pkg::ST_READ;
			jbh_pkg::ST_READ: state_d = jbh_pkg::ST_SCAN;
			jbh_pkg::ST_SCAN: begin
				if (sts.is_zero) begin
					if (sts.at_last) state_d = jbh_pkg::ST_EOB;
					else state_d = jbh_pkg::ST_READ;
				end else if (sts.run_ge16) begin
					state_d = jbh_pkg::ST_ZRL;
				end else if (!sts.out_busy) begin
					if (sts.at_last) state_d = jbh_pkg::ST_LOAD;
					else state_d = jbh_pkg::ST_READ;
				end
			end
			jbh_pkg::ST_ZRL: if (!sts.out_busy) state_d = jbh_pkg::ST_SCAN;
			jbh_pkg::ST_EOB: if (!sts.out_busy) state_d = jbh_pkg::ST_LOAD;
			default: state_d = jbh_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		loading = 1'b0;
		case (state_q)
			jbh_pkg::ST_LOAD: loading = 1'b1;
			jbh_pkg::ST_DC: begin
				cmd.dc_emit = !sts.out_busy;
				cmd.run_clr = 1'b1;
			end
			jbh_pkg::ST_READ: cmd.rd_en = 1'b1;
			jbh_pkg::ST_SCAN: begin
				if (sts.is_zero) begin
					// trailing zeros at the end close with EOB
					cmd.run_inc = 1'b1;
				end else if (!sts.run_ge16 && !sts.out_busy) begin
					cmd.ac_emit = 1'b1;
					cmd.run_clr = 1'b1;
					cmd.last    = sts.at_last;
				end
			end
			jbh_pkg::ST_ZRL: begin
				cmd.zrl_emit  = !sts.out_busy;
				cmd.run_dec16 = !sts.out_busy;
			end
			jbh_pkg::ST_EOB: begin
				cmd.eob_emit = !sts.out_busy;
				cmd.last     = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/jbh_datapath.sv -----
// ---------------------------------------------------------------------------
// jbh_datapath
// Zigzag block store, DC predictor, run counter and symbol output register.
// ---------------------------------------------------------------------------
`include "jpeg_block_huffman_encoder_macros.svh"

module jbh_datapath #(
	parameter int COEFF_WIDTH = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic signed [COEFF_WIDTH-1:0] wr_data,
	output logic                      blk_full,
	input  logic                      dc_pred_en,
	input  logic [3:0]                dead_zone,
	input  jbh_pkg::jbh_cmd_t         cmd,
	output jbh_pkg::jbh_sts_t         sts,
	output logic                      out_valid,
	input  logic                      out_ready,
	output jbh_pkg::jbh_sym_t         out_sym
);

	logic signed [COEFF_WIDTH-1:0] store_q [jbh_pkg::BLOCK_SIZE];
	logic [5:0]  load_idx_q;
	logic [5:0]  rd_idx_q;
	logic signed [COEFF_WIDTH-1:0] rd_data_q;
	logic signed [11:0] prev_dc_q;
	logic [5:0]  run_q;
	logic        busy_q;
	jbh_pkg::jbh_sym_t sym_q;

	// load side: store by zigzag position
	always_ff @(posedge clk) begin
		if (wr_en) store_q[jbh_pkg::zig_pos(load_idx_q)] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
		end else if (wr_en) begin
			load_idx_q <= load_idx_q + 6'd1;
		end
	end
	assign blk_full = wr_en && (load_idx_q == 6'd63);

	// scan read port; DC reads entry 0 first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (blk_full) begin
			rd_idx_q <= 6'd0;
		end else if (cmd.rd_en) begin
			rd_idx_q <= rd_idx_q + 6'd1;
		end
	end

	// hold the fetched entry while a symbol waits or ZRLs go out
	always_ff @(posedge clk) begin
		if (cmd.rd_en || blk_full)
			rd_data_q <= store_q[cmd.rd_en ? rd_idx_q + 6'd1 : 6'd0];
	end

	// saturation and magnitude
	logic signed [16:0] rd_ext;
	logic [16:0] rd_mag;
	logic signed [12:0] dc_sat;
	logic signed [13:0] dc_diff;
	logic signed [12:0] diff_sat;
	logic [10:0] dc_mag;
	logic [3:0]  dc_cat;
	logic [10:0] dc_amp;
	logic signed [11:0] ac_sat;
	logic [10:0] ac_mag;
	logic [3:0]  ac_cat;
	logic [10:0] ac_amp;

	always_comb begin
		rd_ext = 17'(rd_data_q);
		rd_mag = rd_ext[16] ? 17'(-rd_ext) : 17'(rd_ext);

		if (rd_ext > 17'(jbh_pkg::DC_MAX))
			dc_sat = 13'sd2047;
		else if (rd_ext < -17'(jbh_pkg::DC_MAX))
			dc_sat = -13'sd2047;
		else
			dc_sat = 13'(rd_ext);

		dc_diff = dc_pred_en ? 14'(dc_sat) - 14'(prev_dc_q) : 14'(dc_sat);
		if (dc_diff > 14'sd2047) diff_sat = 13'sd2047;
		else if (dc_diff < -14'sd2047) diff_sat = -13'sd2047;
		else diff_sat = 13'(dc_diff);

		dc_mag = diff_sat[12] ? 11'(-diff_sat) : 11'(diff_sat);
		dc_cat = jbh_pkg::category(dc_mag);
		dc_amp = diff_sat[12] ? 11'(diff_sat - 13'sd1) & 11'((12'd1 << dc_cat) - 12'd1)
			: dc_mag;

		if (rd_ext > 17'(jbh_pkg::AC_MAX))
			ac_sat = 12'sd1023;
		else if (rd_ext < -17'(jbh_pkg::AC_MAX))
			ac_sat = -12'sd1023;
		else
			ac_sat = 12'(rd_ext);
		ac_mag = ac_sat[11] ? 11'(-ac_sat) : 11'(ac_sat);
		ac_cat = jbh_pkg::category(ac_mag);
		ac_amp = ac_sat[11] ? 11'(ac_sat - 12'sd1) & 11'((12'd1 << ac_cat) - 12'd1)
			: ac_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_dc_q <= '0;
		end else if (cmd.dc_emit) begin
			prev_dc_q <= 12'(dc_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (cmd.run_clr) begin
			run_q <= '0;
		end else if (cmd.run_inc) begin
			run_q <= run_q + 6'd1;
		end else if (cmd.run_dec16) begin
			run_q <= run_q - 6'd16;
		end
	end

	assign sts.is_zero  = rd_mag <= 17'(dead_zone);
	assign sts.run_ge16 = run_q >= 6'd16;
	assign sts.at_last  = rd_idx_q == 6'd63;
	assign sts.out_busy = busy_q && !out_ready;

	logic emit;
	assign emit = cmd.dc_emit | cmd.ac_emit | cmd.zrl_emit | cmd.eob_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			busy_q <= 1'b1;
		end else if (out_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sym_q.last <= cmd.last;
			if (cmd.dc_emit) begin
				sym_q.kind <= jbh_pkg::KIND_DC;
				sym_q.code <= jbh_pkg::dc_code(dc_cat);
				sym_q.len  <= jbh_pkg::dc_len(dc_cat);
				sym_q.amp  <= dc_amp;
				sym_q.alen <= dc_cat;
			end else if (cmd.ac_emit) begin
				sym_q.kind <= jbh_pkg::KIND_AC;
				sym_q.code <= jbh_pkg::ac_code(run_q[3:0], ac_cat);
				sym_q.len  <= jbh_pkg::ac_len(run_q[3:0], ac_cat);
				sym_q.amp  <= ac_amp;
				sym_q.alen <= ac_cat;
			end else if (cmd.zrl_emit) begin
				sym_q.kind <= jbh_pkg::KIND_ZRL;
				sym_q.code <= jbh_pkg::ZRL_CODE;
				sym_q.len  <= jbh_pkg::ZRL_LEN;
				sym_q.amp  <= '0;
				sym_q.alen <= '0;
			end else begin
				sym_q.kind <= jbh_pkg::KIND_EOB;
				sym_q.code <= jbh_pkg::EOB_CODE;
				sym_q.len  <= jbh_pkg::EOB_LEN;
				sym_q.amp  <= '0;
				sym_q.alen <= '0;
			end
		end
	end

	assign out_valid = busy_q;
	assign out_sym   = sym_q;

	`JBH_ASSERT_IMP(a_no_overwrite, clk, arst_n, busy_q && !out_ready, !emit,
		"symbol issued over an untaken beat")
	`JBH_ASSERT_IMP(a_one_emit, clk, arst_n, emit,
		$onehot({cmd.dc_emit, cmd.ac_emit, cmd.zrl_emit, cmd.eob_emit}),
		"more than one symbol kind issued")
	`JBH_ASSERT_NXT(a_run_bound, clk, arst_n, cmd.ac_emit, run_q == 6'd0,
		"run not cleared after AC symbol")

endmodule
